/* design/svfe_pkg.sv */
package svfe_pkg;

    // Input word layout and output byte width.
    localparam int NEEDLE_W   = 16;
    localparam int LED_W      = 6;
    localparam int IN_DATA_W  = 24;
    localparam int BYTE_W     = 8;

    // Needle clamp limits.
    localparam logic signed [NEEDLE_W-1:0] NEEDLE_MAX = 16'sd12000;
    localparam logic signed [NEEDLE_W-1:0] NEEDLE_MIN = -16'sd10000;

    // Frame layout: byte positions within the 15-byte frame.
    localparam int FRAME_LEN = 15;
    localparam int IDX_W     = 4;
    localparam logic [IDX_W-1:0] IDX_HDR0     = 4'd0;
    localparam logic [IDX_W-1:0] IDX_HDR1     = 4'd1;
    localparam logic [IDX_W-1:0] IDX_HDR2     = 4'd2;
    localparam logic [IDX_W-1:0] IDX_HDR3     = 4'd3;
    localparam logic [IDX_W-1:0] IDX_HDR4     = 4'd4;
    localparam logic [IDX_W-1:0] IDX_HDR5     = 4'd5;
    localparam logic [IDX_W-1:0] IDX_NDL_HI   = 4'd6;
    localparam logic [IDX_W-1:0] IDX_NDL_LO   = 4'd7;
    localparam logic [IDX_W-1:0] IDX_LEDS     = 4'd8;
    localparam logic [IDX_W-1:0] IDX_PAD0     = 4'd9;
    localparam logic [IDX_W-1:0] IDX_NDL_HI2  = 4'd10;
    localparam logic [IDX_W-1:0] IDX_NDL_LO2  = 4'd11;
    localparam logic [IDX_W-1:0] IDX_PAD1     = 4'd12;
    localparam logic [IDX_W-1:0] IDX_CRC_HI   = 4'd13;
    localparam logic [IDX_W-1:0] IDX_CRC_LO   = 4'd14;
    localparam logic [IDX_W-1:0] IDX_CRC_FIRST = IDX_HDR2;
    localparam logic [IDX_W-1:0] IDX_CRC_LAST  = IDX_PAD1;

    // Fixed header bytes.
    localparam logic [BYTE_W-1:0] HDR_B0 = 8'h53;
    localparam logic [BYTE_W-1:0] HDR_B1 = 8'h54;
    localparam logic [BYTE_W-1:0] HDR_B2 = 8'h50;
    localparam logic [BYTE_W-1:0] HDR_B3 = 8'h48;
    localparam logic [BYTE_W-1:0] HDR_B4 = 8'h06;
    localparam logic [BYTE_W-1:0] HDR_B5 = 8'h02;
    localparam logic [BYTE_W-1:0] PAD_B  = 8'h00;

    // CRC-16 with polynomial 0x1021, zero seed, MSB first.
    localparam int CRC_W = 16;
    localparam logic [CRC_W-1:0] CRC_GEN  = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

    // Request queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    // One classified request: clamped needle and packed LED bits.
    typedef struct packed {
        logic [NEEDLE_W-1:0] needle;
        logic [LED_W-1:0]    leds;
    } t_req;

    // Head of the queue as the back sees it.
    typedef struct packed {
        logic valid;
        t_req req;
    } t_q_head;

endpackage

/* design/svfe_front.sv */
module svfe_front (
    input  logic [svfe_pkg::IN_DATA_W-1:0] i_tdata,
    output svfe_pkg::t_req                 o_req
);
    import svfe_pkg::*;

    logic signed [NEEDLE_W-1:0] w_needle;
    logic signed [NEEDLE_W-1:0] w_clamped;

    // Clamp the needle into its displayable range.
    always_comb begin
        w_needle = $signed(i_tdata[NEEDLE_W-1:0]);
        if (w_needle > NEEDLE_MAX) begin
            w_clamped = NEEDLE_MAX;
        end else if (w_needle < NEEDLE_MIN) begin
            w_clamped = NEEDLE_MIN;
        end else begin
            w_clamped = w_needle;
        end
    end

    // Pack the LED flags in their bit order.
    assign o_req.needle = w_clamped;
    assign o_req.leds   = i_tdata[NEEDLE_W +: LED_W];

endmodule

/* design/svfe_fifo.sv */
module svfe_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  svfe_pkg::t_req   i_req,
    output logic             o_full,
    input  logic             i_pop,
    output svfe_pkg::t_q_head o_head
);
    import svfe_pkg::*;

    t_req                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, n_wptr;
    logic [QUEUE_AW-1:0] r_rptr, n_rptr;
    logic [QUEUE_CW-1:0] r_count, n_count;

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_req;
        end
    end

    assign o_full       = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.req   = r_mem[r_rptr];

endmodule

/* design/svfe_back.sv */
module svfe_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  svfe_pkg::t_q_head             i_head,
    output logic                          o_pop,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [svfe_pkg::BYTE_W-1:0]   o_tdata,
    output logic                          o_tlast
);
    import svfe_pkg::*;

    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic              r_valid, n_valid;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_last, n_last;
    logic              w_adv;
    logic [BYTE_W-1:0] w_sel;

    // One byte through the CRC register, eight shift steps.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] acc;
        acc = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if (acc[CRC_W-1]) begin
                acc = (acc << 1) ^ CRC_GEN;
            end else begin
                acc = acc << 1;
            end
        end
        return acc;
    endfunction

    // Select the frame byte at the current position.
    always_comb begin
        case (r_idx)
            IDX_HDR0:    w_sel = HDR_B0;
            IDX_HDR1:    w_sel = HDR_B1;
            IDX_HDR2:    w_sel = HDR_B2;
            IDX_HDR3:    w_sel = HDR_B3;
            IDX_HDR4:    w_sel = HDR_B4;
            IDX_HDR5:    w_sel = HDR_B5;
            IDX_NDL_HI:  w_sel = i_head.req.needle[NEEDLE_W-1 -: BYTE_W];
            IDX_NDL_LO:  w_sel = i_head.req.needle[BYTE_W-1:0];
            IDX_LEDS:    w_sel = {{(BYTE_W-LED_W){1'b0}}, i_head.req.leds};
            IDX_PAD0:    w_sel = PAD_B;
            IDX_NDL_HI2: w_sel = i_head.req.needle[NEEDLE_W-1 -: BYTE_W];
            IDX_NDL_LO2: w_sel = i_head.req.needle[BYTE_W-1:0];
            IDX_PAD1:    w_sel = PAD_B;
            IDX_CRC_HI:  w_sel = r_crc[CRC_W-1 -: BYTE_W];
            IDX_CRC_LO:  w_sel = r_crc[BYTE_W-1:0];
            default:     w_sel = PAD_B;
        endcase
    end

    // Sequencer: one byte per cycle whenever a request waits and the output word can move.
    always_comb begin
        w_adv   = !r_valid || i_tready;
        o_pop   = w_adv && i_head.valid && (r_idx == IDX_CRC_LO);
        n_idx   = r_idx;
        n_crc   = r_crc;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        if (w_adv) begin
            n_valid = i_head.valid;
            n_byte  = w_sel;
            n_last  = (r_idx == IDX_CRC_LO);
            if (i_head.valid) begin
                if (r_idx == IDX_CRC_LO) begin
                    n_idx = IDX_HDR0;
                    n_crc = CRC_INIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx inside {[IDX_CRC_FIRST:IDX_CRC_LAST]}) begin
                        n_crc = crc_byte(r_crc, w_sel);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= IDX_HDR0;
            r_crc   <= CRC_INIT;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_crc   <= n_crc;
            r_valid <= n_valid;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_byte;
    assign o_tlast  = r_last;

endmodule

/* design/snap_vario_frame_encoder_unit.sv */
// Encoder of update requests into 15-byte display frames.
// Slave channel s_axis: one word per request carrying the needle value and
// six LED flags. Master channel m_axis: the frame, one byte per word, with
// tlast on the CRC low byte that closes each frame.
// The needle is clamped to -10000..12000, the LEDs are packed into bits 0..5,
// and the frame ends in a CRC-16 (poly 0x1021, seed 0) over bytes 2 to 12.
// With the sequencer idle, a request word passes through the queue and then the
// output register before its first frame byte is valid. The byte sequencer moves
// one byte per cycle through the output register while m_axis_tready allows.
// A two-entry queue lies between the classifying front and the sequencer,
// so a new request is taken while the current frame is still being sent;
// s_axis_tready falls only while that queue is full.
// When the receiver drops m_axis_tready, the output word holds and the
// sequencer waits; no byte is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the queue, drops m_axis_tvalid
// and restarts the sequencer at the first header byte.
module snap_vario_frame_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] needle_value, [16] led_fast_down, [17] led_down, [18] led_up,
    // [19] led_fast_up, [20] led_minus, [21] led_plus, [23:22] zero
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] frame_byte
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);
    import svfe_pkg::*;

    t_req    w_req;
    t_q_head w_head;
    logic    w_full;
    logic    w_push;
    logic    w_pop;

    // Front: clamp and pack the request word.
    svfe_front u_front (
        .i_tdata (s_axis_tdata),
        .o_req   (w_req)
    );

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && s_axis_tready;

    // Queue of classified requests.
    svfe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_req),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // Back: frame sequencer and CRC.
    svfe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

    // A request leaves the queue only when one is there.
    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("queue popped while empty");

    // A full queue means the sequencer has work to do.
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_head.valid)
        else $error("queue full with no request at its head");

    // Retiring a request puts the closing byte on the output next cycle.
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (m_axis_tvalid && m_axis_tlast))
        else $error("frame retired without a closing byte");

endmodule

/* test/svfe_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the frame encoder and predicts every frame byte.
// Each accepted request word queues its 15 expected bytes; each accepted
// output word is compared with the oldest of them.
module svfe_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // [15:0] needle_value, [21:16] LED flags, [23:22] zero
    input  logic [23:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] frame_byte
    input  logic [7:0]  i_m_tdata,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    import svfe_pkg::*;

    // One expected output word: frame byte and end-of-frame flag.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_frame_word;

    localparam int REPORT_LIMIT = 10;

    t_frame_word frame_bytes_due[$];
    int          mismatch_count = 0;

    // Builds the frame for one request word and queues its bytes in order.
    function automatic void queue_frame(input logic [IN_DATA_W-1:0] word);
        logic signed [NEEDLE_W-1:0] needle;
        logic [LED_W-1:0]           leds;
        logic [BYTE_W-1:0]          frame [FRAME_LEN];
        logic [CRC_W-1:0]           crc;
        t_frame_word                entry;

        needle = word[NEEDLE_W-1:0];
        leds   = word[NEEDLE_W +: LED_W];

        // Clamp the needle before it is split into bytes.
        if (needle > NEEDLE_MAX) begin
            needle = NEEDLE_MAX;
        end
        if (needle < NEEDLE_MIN) begin
            needle = NEEDLE_MIN;
        end

        frame[IDX_HDR0]    = HDR_B0;
        frame[IDX_HDR1]    = HDR_B1;
        frame[IDX_HDR2]    = HDR_B2;
        frame[IDX_HDR3]    = HDR_B3;
        frame[IDX_HDR4]    = HDR_B4;
        frame[IDX_HDR5]    = HDR_B5;
        frame[IDX_NDL_HI]  = needle[15:8];
        frame[IDX_NDL_LO]  = needle[7:0];
        frame[IDX_LEDS]    = {2'b00, leds};
        frame[IDX_PAD0]    = PAD_B;
        frame[IDX_NDL_HI2] = needle[15:8];
        frame[IDX_NDL_LO2] = needle[7:0];
        frame[IDX_PAD1]    = PAD_B;

        // Bitwise CRC, most significant bit first, over the covered bytes.
        crc = CRC_INIT;
        for (int i = IDX_CRC_FIRST; i <= IDX_CRC_LAST; i++) begin
            crc ^= {frame[i], 8'h00};
            for (int b = 0; b < 8; b++) begin
                crc = crc[CRC_W-1] ? ((crc << 1) ^ CRC_GEN) : (crc << 1);
            end
        end
        frame[IDX_CRC_HI] = crc[15:8];
        frame[IDX_CRC_LO] = crc[7:0];

        for (int k = 0; k < FRAME_LEN; k++) begin
            entry.data = frame[k];
            entry.last = (k == FRAME_LEN - 1);
            frame_bytes_due.push_back(entry);
        end
    endfunction

    // Compare output words first, then record the request accepted at this edge.
    always @(posedge i_clk) begin
        t_frame_word seen;
        t_frame_word want;

        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                seen.data = i_m_tdata;
                seen.last = i_m_tlast;
                if (frame_bytes_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("ERROR at %0t: word data %h last %b with no byte due",
                                 $time, seen.data, seen.last);
                    end
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("ERROR at %0t: expected data %h last %b, got data %h last %b",
                                     $time, want.data, want.last, seen.data, seen.last);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                queue_frame(i_s_tdata);
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= frame_bytes_due.size();
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import svfe_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 65;
    localparam int SETTLE_TICKS = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [15:0] needle_value, [21:16] LED flags, [23:22] zero
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] frame_byte
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    int fail_count;
    int bytes_pending;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int dst_stall_pct = 0;

    snap_vario_frame_encoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    svfe_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (bytes_pending)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver back-pressure, one fresh decision per cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= (int'($urandom_range(99)) >= dst_stall_pct);
    end

    // Offers one request word, with a random gap first, and waits for its acceptance.
    task automatic send_request(input logic [NEEDLE_W-1:0] needle,
                                input logic [LED_W-1:0] leds);
        while (int'($urandom_range(99)) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, leds, needle};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    // Holds the sender off until every queued frame byte has come out.
    task automatic drain_frames();
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (bytes_pending != 0);
    endtask

    // Needle values spread over the whole range, the clamp limits and the extremes.
    function automatic logic [NEEDLE_W-1:0] random_needle();
        int v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = int'(NEEDLE_MIN) + int'($urandom_range(22000));
            2: v = ($urandom_range(1) ? int'(NEEDLE_MAX) : int'(NEEDLE_MIN))
                   + int'($urandom_range(6)) - 3;
            default: v = $urandom_range(1) ? 32767 - int'($urandom_range(3))
                                           : -32768 + int'($urandom_range(3));
        endcase
        return v[NEEDLE_W-1:0];
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: clamp limits and their neighbors, extremes, every LED bit.
        send_request(16'sd0, 6'h00);
        send_request(16'sd12000, 6'h3f);
        send_request(16'sd12001, 6'h01);
        send_request(16'sd11999, 6'h02);
        send_request(-16'sd10000, 6'h04);
        send_request(-16'sd10001, 6'h08);
        send_request(-16'sd9999, 6'h10);
        send_request(16'h7fff, 6'h20);
        send_request(16'h8000, 6'h3f);
        send_request(16'hffff, 6'h00);
        send_request(16'sd1, 6'h15);
        send_request(16'sd255, 6'h2a);
        send_request(16'sd256, 6'h00);
        send_request(-16'sd256, 6'h3f);
        send_request(16'h5555, 6'h0f);
        send_request(16'haaaa, 6'h30);
        drain_frames();

        // Random words over the four idling phases, each ending in a full drain.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 0;
                    dst_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 65;
                    dst_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    dst_stall_pct = 65;
                end
                default: begin
                    src_idle_pct  = 29;
                    dst_stall_pct = 29;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                send_request(random_needle(), LED_W'($urandom_range(63)));
            end
            drain_frames();
        end

        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
design/svfe_pkg.sv
design/svfe_front.sv
design/svfe_fifo.sv
design/svfe_back.sv
design/snap_vario_frame_encoder_unit.sv
test/svfe_checker.sv
test/tb.sv
